[src/spbm_pkg.sv]
`timescale 1ns / 1ps
package spbm_pkg;

  localparam int SP_W        = 32;
  localparam int THREAD_W    = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int THREADS_DEF = 64;

  localparam logic [SP_W-1:0] BELOW_LIMIT_RST = 32'd50000;
  localparam logic [SP_W-1:0] ABOVE_LIMIT_RST = 32'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BELOW_LIMIT = 1'b0,
    CFG_ABOVE_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic take;
    logic exec;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  typedef struct packed {
    logic [SP_W-1:0] lo;
    logic [SP_W-1:0] hi;
  } marks_t;

endpackage

[src/spbm_in_if.sv]
`timescale 1ns / 1ps
interface spbm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [spbm_pkg::THREAD_W-1:0] thread;
  logic [spbm_pkg::SP_W-1:0]     stack_pointer;

  modport source (output valid, output operation, output thread, output stack_pointer,
                  input ready);
  modport sink (input valid, input operation, input thread, input stack_pointer,
                output ready);
endinterface

[src/spbm_out_if.sv]
`timescale 1ns / 1ps
interface spbm_out_if;
  logic                      valid;
  logic                      ready;
  logic                      pivot_detected;
  logic [spbm_pkg::SP_W-1:0] stack_usage;

  modport source (output valid, output pivot_detected, output stack_usage, input ready);
  modport sink (input valid, input pivot_detected, input stack_usage, output ready);
endinterface

[src/spbm_ctrl.sv]
`timescale 1ns / 1ps
module spbm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  spbm_pkg::dp_sts_t   sts_i,
  output spbm_pkg::ctrl_cmd_t cmd_o
);

  spbm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spbm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      spbm_pkg::ST_IDLE: begin
        cmd_o.take = 1'b1;
        if (in_valid_i) begin
          state_d = spbm_pkg::ST_EXEC;
        end
      end
      spbm_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = spbm_pkg::ST_FIN;
      end
      spbm_pkg::ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = spbm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = spbm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[src/spbm_dp.sv]
`timescale 1ns / 1ps
module spbm_dp #(
  parameter int THREADS = spbm_pkg::THREADS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [spbm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [spbm_pkg::SP_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_operation_i,
  input  logic [spbm_pkg::THREAD_W-1:0]  in_thread_i,
  input  logic [spbm_pkg::SP_W-1:0]      in_stack_pointer_i,
  input  spbm_pkg::ctrl_cmd_t            cmd_i,
  output spbm_pkg::dp_sts_t              sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_pivot_detected_o,
  output logic [spbm_pkg::SP_W-1:0]      out_stack_usage_o
);

  localparam int AW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int EW = spbm_pkg::THREAD_W + AW;

  logic [spbm_pkg::SP_W-1:0] below_q, above_q;
  logic                      op_q, thr_ok_q;
  logic [AW-1:0]             addr_q;
  logic [spbm_pkg::SP_W-1:0] sp_q;
  spbm_pkg::marks_t          rd_q;
  spbm_pkg::marks_t          mem [THREADS];
  spbm_pkg::marks_t          marks_q, marks_d;
  logic                      pivot_q, pivot_d;
  logic                      wr_en;
  logic                      out_valid_q;
  logic                      out_pivot_q;
  logic [spbm_pkg::SP_W-1:0] out_usage_q;
  logic [EW-1:0]             thr_ext;
  logic                      accept;
  logic [spbm_pkg::SP_W-1:0] drop, rise;
  logic                      sp_lt, sp_gt, piv_lo, piv_hi;

  assign accept  = cmd_i.take && in_valid_i;
  assign thr_ext = {{AW{1'b0}}, in_thread_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      below_q <= spbm_pkg::BELOW_LIMIT_RST;
      above_q <= spbm_pkg::ABOVE_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (spbm_pkg::cfg_idx_e'(cfg_idx_i))
        spbm_pkg::CFG_BELOW_LIMIT: below_q <= cfg_data_i;
        spbm_pkg::CFG_ABOVE_LIMIT: above_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= in_operation_i;
      thr_ok_q <= (thr_ext < EW'(THREADS));
      addr_q   <= thr_ext[AW-1:0];
      sp_q     <= in_stack_pointer_i;
      rd_q     <= mem[thr_ext[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[addr_q] <= marks_d;
    end
  end

  assign drop   = rd_q.lo - sp_q;
  assign rise   = sp_q - rd_q.hi;
  assign sp_lt  = sp_q < rd_q.lo;
  assign sp_gt  = sp_q > rd_q.hi;
  assign piv_lo = sp_lt && (drop > below_q);
  assign piv_hi = sp_gt && (rise >= above_q);

  always_comb begin
    pivot_d = 1'b0;
    marks_d = '0;
    wr_en   = 1'b0;
    if (thr_ok_q) begin
      if (op_q == spbm_pkg::OP_START) begin
        marks_d = '{lo: sp_q, hi: sp_q};
        wr_en   = cmd_i.exec;
      end else if (piv_lo || piv_hi) begin
        pivot_d = 1'b1;
        marks_d = rd_q;
      end else begin
        marks_d.lo = sp_lt ? sp_q : rd_q.lo;
        marks_d.hi = sp_gt ? sp_q : rd_q.hi;
        wr_en      = cmd_i.exec;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      marks_q <= marks_d;
      pivot_q <= pivot_d;
    end
    if (cmd_i.load) begin
      out_pivot_q <= pivot_q;
      out_usage_q <= marks_q.hi - marks_q.lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free      = !out_valid_q || out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign out_pivot_detected_o = out_pivot_q;
  assign out_stack_usage_o   = out_usage_q;

endmodule

[src/stack_pointer_bounds_monitor.sv]
`timescale 1ns / 1ps
// Each word is accepted, its marks read-modify-written, and its result loaded.
// A new word is accepted only after the previous result load; the per-thread mark memory is read
//   at accept, written back in the next cycle for a valid thread with no pivot.
// A full result register stalls the next load until it is taken.
// Reset: asynchronous, active low; clears control, loads the default limits,
//   mark memory is not cleared.
module stack_pointer_bounds_monitor #(
  parameter int THREADS = spbm_pkg::THREADS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [spbm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [spbm_pkg::SP_W-1:0]      cfg_data_i,
  spbm_in_if.sink                        in_i,
  spbm_out_if.source                     out_o
);

  spbm_pkg::ctrl_cmd_t cmd;
  spbm_pkg::dp_sts_t   sts;

  spbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spbm_dp #(
    .THREADS (THREADS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_i.valid),
    .in_operation_i       (in_i.operation),
    .in_thread_i          (in_i.thread),
    .in_stack_pointer_i   (in_i.stack_pointer),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .out_valid_o          (out_o.valid),
    .out_ready_i          (out_o.ready),
    .out_pivot_detected_o (out_o.pivot_detected),
    .out_stack_usage_o    (out_o.stack_usage)
  );

  assign in_i.ready = cmd.take;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> cmd.exec)
    else $error("accepted word not processed next cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !out_o.valid || out_o.ready)
    else $error("result overwritten before taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.load))
    else $error("result valid without load");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.take, cmd.exec, cmd.load}) <= 1)
    else $error("overlapping controller commands");

endmodule
